FILE: sv/adc_average_power_monitor_assert.svh
// Assertion macros used by the power monitor controller (apm_ctrl).
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ADC_AVERAGE_POWER_MONITOR_ASSERT_SVH
`define ADC_AVERAGE_POWER_MONITOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define APM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define APM_ASSERT_NEVER(name, cond, msg) \
  `APM_ASSERT(name, !(cond), msg)

`endif

FILE: sv/apm_pkg.sv
// Shared types and constants for the ADC average power monitor.
// No dependencies; imported by every module of the block.
package apm_pkg;

  localparam int ADC_W        = 10;
  localparam int ADC_MAX      = 1023;
  localparam int FS_W         = 16;
  localparam int MV_W         = 16;
  localparam int PROD_W       = 32;
  localparam int SCALE_SHIFT  = 10;
  localparam int DEF_SAMPLES  = 16;
  localparam logic [FS_W-1:0] VFS_RESET = 16'd25000;
  localparam logic [FS_W-1:0] CFS_RESET = 16'd2500;

  // Shared divider geometry: dividend, quotient, reciprocal operand and product widths.
  localparam int DIV_DW = 33;
  localparam int DIV_QW = 17;
  localparam int DIV_XW = 27;
  localparam int DIV_MW = 28;
  localparam int DIV_PW = DIV_XW + DIV_MW;

  // Divide by one million as a shift by six, then a reciprocal multiply by 15625.
  localparam int PWR_PRESHIFT = 6;
  localparam int PWR_ODD      = 15625;
  localparam int PWR_SHIFT    = DIV_XW + $clog2(PWR_ODD);
  localparam logic [DIV_MW-1:0] PWR_RECIP =
      DIV_MW'(((64'd1 << PWR_SHIFT) + 64'(PWR_ODD) - 64'd1) / 64'(PWR_ODD));

  localparam logic [DIV_DW-1:0] PWR_ROUND   = 33'd500000;
  localparam logic [MV_W-1:0]   PWR_MAX     = 16'hFFFF;

  // Register indexes.
  localparam logic REG_VFS = 1'b0;
  localparam logic REG_CFS = 1'b1;

  // Multiplier operand selects.
  localparam logic [1:0] MUL_MV = 2'd0;
  localparam logic [1:0] MUL_MA = 2'd1;
  localparam logic [1:0] MUL_PW = 2'd2;

  typedef struct packed {
    logic       take;
    logic       div_start;
    logic       div_pwr;
    logic       store_vavg;
    logic       store_cavg;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       store_mv;
    logic       store_ma;
    logic       store_pw;
    logic       out_load;
  } apm_cmd_t;

  typedef struct packed {
    logic blk_done;
    logic blk_volt;
    logic div_busy;
    logic div_done;
    logic out_free;
  } apm_sts_t;

endpackage

FILE: sv/adc_average_power_monitor.sv
// ADC average power monitor: averages current and voltage conversions and reports power.
// Uses the register file below. Blocks: apm_ctrl, apm_datapath (with apm_div).
//
// Input words (in_*): one 10-bit conversion as low byte and high byte in in_tdata,
// channel in in_tuser (0 current, 1 voltage). Each channel sums SAMPLES_PER_AVERAGE
// words and truncates to an average. A closed voltage block stores its average; a
// closed current block emits one output word (out_*): voltage_mv, current_ma and the
// rounded power mV*mA/1e6, clamped to 65535 with out_tuser set on overflow.
// Throughput: words that do not close a block are taken back to back. A word that
// closes a voltage block holds the input through the divide; one that closes a current
// block holds it through the reciprocal divide (used twice per current block) and the
// shared 16x16 multiplier (three products), and out_tvalid rises in the same cycle as the
// input is freed. The output register lets the next word enter while a result waits; a
// stalled receiver only holds the next result at its load.
// Reset (rst_n, synchronous) clears sums, counts and the stored voltage average and
// loads full-scale defaults 25000 mV and 2500 mA. Write the full-scale registers
// through cfg_* (address 0 voltage, 4 current) only while the block is idle.
module adc_average_power_monitor #(
  parameter int SAMPLES_PER_AVERAGE = apm_pkg::DEF_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] adc_low_byte, [15:8] adc_high_byte
  input  logic        in_tuser,    // [0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] voltage_mv, [31:16] current_ma, [47:32] power_w
  output logic        out_tuser,   // [0] saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import apm_pkg::*;

  logic [FS_W-1:0] vfs_r, cfs_r;
  logic            cfg_wr;
  apm_cmd_t        cmd;
  apm_sts_t        sts;

  // Full-scale registers; the address bit above the word offset picks the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfs_r <= VFS_RESET;
      cfs_r <= CFS_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_VFS: vfs_r <= cfg_pwdata[FS_W-1:0];
        REG_CFS: cfs_r <= cfg_pwdata[FS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CFS) ? 32'(cfs_r) : 32'(vfs_r);

  apm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  apm_datapath #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .adc_low_byte  (in_tdata[7:0]),
    .adc_high_byte (in_tdata[15:8]),
    .channel       (in_tuser),
    .vfs           (vfs_r),
    .cfs           (cfs_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

FILE: sv/apm_div.sv
// Constant divider by reciprocal multiplication, shared by averaging and power.
// Depends on apm_pkg for its widths and the power reciprocal.
module apm_div #(
  parameter int SAMPLES_PER_AVERAGE = apm_pkg::DEF_SAMPLES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       pwr,
  input  logic [apm_pkg::DIV_DW-1:0] dividend,
  output logic                       busy,
  output logic                       done,
  output logic [apm_pkg::DIV_QW-1:0] quotient
);
  import apm_pkg::*;

  // Rounded-up reciprocal of the sample count, exact for every block sum.
  localparam int SUM_W     = $clog2(ADC_MAX * SAMPLES_PER_AVERAGE + 1);
  localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [DIV_MW-1:0] AVG_RECIP = DIV_MW'(((64'd1 << AVG_SHIFT) +
      64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              pwr_r, pwr_nxt;
  logic [DIV_XW-1:0] x_r, x_nxt;
  logic [DIV_MW-1:0] m_r, m_nxt;
  logic [DIV_PW-1:0] prod_r, prod_nxt;

  // Load operands on start, multiply in the next cycle, flag done after it.
  always_comb begin
    busy_nxt = 1'b0;
    done_nxt = busy_r;
    pwr_nxt  = pwr_r;
    x_nxt    = x_r;
    m_nxt    = m_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      pwr_nxt  = pwr;
      x_nxt    = pwr ? DIV_XW'(dividend >> PWR_PRESHIFT) : DIV_XW'(dividend);
      m_nxt    = pwr ? PWR_RECIP : AVG_RECIP;
    end
    if (busy_r) begin
      prod_nxt = DIV_PW'(x_r) * DIV_PW'(m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    pwr_r  <= pwr_nxt;
    x_r    <= x_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = pwr_r ? DIV_QW'(prod_r >> PWR_SHIFT) : DIV_QW'(prod_r >> AVG_SHIFT);

endmodule

FILE: sv/apm_datapath.sv
// Datapath: per-channel sums, averages, scaling multiplier, divider and output word.
// Depends on apm_pkg and apm_div.
module apm_datapath #(
  parameter int SAMPLES_PER_AVERAGE = apm_pkg::DEF_SAMPLES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               adc_low_byte,
  input  logic [7:0]               adc_high_byte,
  input  logic                     channel,
  input  logic [apm_pkg::FS_W-1:0] vfs,
  input  logic [apm_pkg::FS_W-1:0] cfs,
  input  apm_pkg::apm_cmd_t        cmd,
  output apm_pkg::apm_sts_t        sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [47:0]              out_tdata,
  output logic                     out_tuser
);
  import apm_pkg::*;

  localparam int SUM_W = $clog2(ADC_MAX * SAMPLES_PER_AVERAGE + 1);
  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [ADC_W-1:0]  code;
  logic [SUM_W-1:0]  vsum_r, csum_r, sum_nxt;
  logic [CNT_W-1:0]  vcnt_r, ccnt_r, cnt_sel;
  logic [ADC_W-1:0]  vavg_r, cavg_r;
  logic [MV_W-1:0]   mv_r, ma_r;
  logic [PROD_W-1:0] prod_r;
  logic [MV_W-1:0]   opa, opb;
  logic [MV_W-1:0]   prod_scaled;
  logic [DIV_QW-1:0] pw_r;
  logic [DIV_DW-1:0] div_dividend;
  logic              div_busy, div_done;
  logic [DIV_QW-1:0] div_q;
  logic              out_valid_r;
  logic [47:0]       out_data_r;
  logic              out_sat_r;
  logic              sat;

  // Assemble the 10-bit conversion and the running sum of its channel.
  assign code    = {adc_high_byte[1:0], adc_low_byte};
  assign cnt_sel = channel ? vcnt_r : ccnt_r;
  assign sum_nxt = (channel ? vsum_r : csum_r) + SUM_W'(code);

  // Accumulate samples; clear the channel when its block closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r <= '0;
      csum_r <= '0;
      vcnt_r <= '0;
      ccnt_r <= '0;
      vavg_r <= '0;
    end else begin
      if (cmd.take) begin
        if (channel) begin
          vsum_r <= sts.blk_done ? '0 : sum_nxt;
          vcnt_r <= sts.blk_done ? '0 : vcnt_r + 1'b1;
        end else begin
          csum_r <= sts.blk_done ? '0 : sum_nxt;
          ccnt_r <= sts.blk_done ? '0 : ccnt_r + 1'b1;
        end
      end
      if (cmd.store_vavg) begin
        vavg_r <= div_q[ADC_W-1:0];
      end
    end
  end

  // Divider operand: block sum over the sample count, or rounded power.
  assign div_dividend = cmd.div_pwr ? (DIV_DW'(prod_r) + PWR_ROUND) : DIV_DW'(sum_nxt);

  apm_div #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .pwr      (cmd.div_pwr),
    .dividend (div_dividend),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared 16x16 multiplier with a registered product.
  assign prod_scaled = prod_r[SCALE_SHIFT +: MV_W];

  always_comb begin
    case (cmd.mul_sel)
      MUL_MV: begin
        opa = MV_W'(vavg_r);
        opb = vfs;
      end
      MUL_MA: begin
        opa = MV_W'(cavg_r);
        opb = cfs;
      end
      MUL_PW: begin
        opa = mv_r;
        opb = prod_scaled;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Hold the intermediate results of one current block.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= opa * opb;
    end
    if (cmd.store_cavg) begin
      cavg_r <= div_q[ADC_W-1:0];
    end
    if (cmd.store_mv) begin
      mv_r <= prod_scaled;
    end
    if (cmd.store_ma) begin
      ma_r <= prod_scaled;
    end
    if (cmd.store_pw) begin
      pw_r <= div_q;
    end
  end

  // Clamp power that does not fit in 16 bits.
  assign sat = pw_r > DIV_QW'(PWR_MAX);

  // Output register: load a word, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {(sat ? PWR_MAX : pw_r[MV_W-1:0]), ma_r, mv_r};
      out_sat_r  <= sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // Status back to the controller.
  always_comb begin
    sts.blk_done = cnt_sel == CNT_LAST;
    sts.blk_volt = channel;
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

FILE: sv/apm_ctrl.sv
// Controller state machine sequencing accumulation, division and scaling.
// Depends on apm_pkg and the assertion macro header.
`include "adc_average_power_monitor_assert.svh"

module apm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output apm_pkg::apm_cmd_t cmd,
  input  apm_pkg::apm_sts_t sts
);
  import apm_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIVV    = 4'd1;
  localparam logic [3:0] S_DIVC    = 4'd2;
  localparam logic [3:0] S_MULV    = 4'd3;
  localparam logic [3:0] S_MULC    = 4'd4;
  localparam logic [3:0] S_MULP    = 4'd5;
  localparam logic [3:0] S_DIVP_GO = 4'd6;
  localparam logic [3:0] S_DIVP    = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.take  = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (cmd.take && sts.blk_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = sts.blk_volt ? S_DIVV : S_DIVC;
        end
      end
      S_DIVV: begin
        if (sts.div_done) begin
          cmd.store_vavg = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DIVC: begin
        if (sts.div_done) begin
          cmd.store_cavg = 1'b1;
          state_nxt      = S_MULV;
        end
      end
      S_MULV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MV;
        state_nxt   = S_MULC;
      end
      S_MULC: begin
        cmd.store_mv = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_MA;
        state_nxt    = S_MULP;
      end
      S_MULP: begin
        cmd.store_ma = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_PW;
        state_nxt    = S_DIVP_GO;
      end
      S_DIVP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_pwr   = 1'b1;
        state_nxt     = S_DIVP;
      end
      S_DIVP: begin
        cmd.div_pwr = 1'b1;
        if (sts.div_done) begin
          cmd.store_pw = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `APM_ASSERT_NEVER(a_start_while_busy, cmd.div_start && sts.div_busy, "divider restarted while busy")
  `APM_ASSERT(a_load_into_free, cmd.out_load |-> sts.out_free, "output word overwritten")
  `APM_ASSERT(a_done_after_busy, sts.div_done |-> $past(sts.div_busy), "divider done without work")
  `APM_ASSERT(a_start_then_busy, cmd.div_start |=> sts.div_busy, "divider did not start")

endmodule
